FILE: hw/rtl/alt_pkg.sv
`default_nettype none

package alt_pkg;

    localparam int SAMPLE_W       = 10;
    localparam int LEVEL_W        = 8;
    localparam int NUM_W          = 20;
    localparam int RECIP_W        = 31;
    localparam int RECIP_SHIFT    = 30;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 10;
    localparam int GROUP_SIZE_DEF = 16;

    localparam logic [SAMPLE_W-1:0] OFFSET       = 10'd20;
    localparam logic [SAMPLE_W-1:0] COMP_DEN     = 10'd1003;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 10'd1023;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 8'd255;
    localparam logic [SAMPLE_W-1:0] LOW_CUT_RST  = 10'd30;
    localparam logic [SAMPLE_W-1:0] HIGH_CUT_RST = 10'd1013;
    localparam logic [LEVEL_W-1:0]  DEADBAND_RST = 8'd5;

    // rounded-up reciprocals scaled by 2^RECIP_SHIFT, exact for the numerators used
    localparam logic [RECIP_W-1:0] COMP_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(COMP_DEN) - 64'd1) / 64'(COMP_DEN));
    localparam logic [RECIP_W-1:0] SCALE_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_CUT  = 2'd0,
        REG_HIGH_CUT = 2'd1,
        REG_DEADBAND = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low_cut;
        logic [SAMPLE_W-1:0] high_cut;
        logic [LEVEL_W-1:0]  deadband;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_CUT,
        ST_COMP,
        ST_TGT,
        ST_STEP,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/alt_in_if.sv
`default_nettype none

interface alt_in_if;
    logic                          valid;
    logic                          ready;
    logic [alt_pkg::SAMPLE_W-1:0]  sample;
    logic                          up_button;
    logic                          down_button;

    modport source (output valid, output sample, output up_button, output down_button,
                    input ready);
    modport sink   (input valid, input sample, input up_button, input down_button,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/alt_out_if.sv
`default_nettype none

interface alt_out_if;
    logic                          valid;
    logic                          ready;
    logic [alt_pkg::SAMPLE_W-1:0]  average;
    logic [alt_pkg::LEVEL_W-1:0]   level;
    logic [alt_pkg::LEVEL_W-1:0]   count_value;
    logic                          level_above;

    modport source (output valid, output average, output level, output count_value,
                    output level_above, input ready);
    modport sink   (input valid, input average, input level, input count_value,
                    input level_above, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/alt_cfg_if.sv
`default_nettype none

interface alt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [alt_pkg::CFG_IDX_W-1:0]   idx;
    logic [alt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/alt_regs.sv
`default_nettype none

module alt_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    alt_cfg_if.sink       i_cfg,
    output alt_pkg::t_cfg o_cfg
);
    import alt_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_cut  <= LOW_CUT_RST;
            r_cfg.high_cut <= HIGH_CUT_RST;
            r_cfg.deadband <= DEADBAND_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.idx))
                REG_LOW_CUT:  r_cfg.low_cut  <= i_cfg.data[SAMPLE_W-1:0];
                REG_HIGH_CUT: r_cfg.high_cut <= i_cfg.data[SAMPLE_W-1:0];
                REG_DEADBAND: r_cfg.deadband <= i_cfg.data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/alt_div.sv
`default_nettype none

module alt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [alt_pkg::NUM_W-1:0]   i_num,
    input  logic [alt_pkg::RECIP_W-1:0] i_recip,
    output logic                        o_done,
    output logic [alt_pkg::NUM_W-1:0]   o_quo
);
    import alt_pkg::*;

    localparam int PROD_W = NUM_W + RECIP_W;

    logic               r_busy;
    logic               r_done;
    logic [NUM_W-1:0]   r_num;
    logic [RECIP_W-1:0] r_recip;
    logic [NUM_W-1:0]   r_quo;
    logic [PROD_W-1:0]  w_prod;

    // quotient by a constant from the scaled reciprocal product
    assign w_prod = PROD_W'(r_num) * PROD_W'(r_recip);

    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num   <= i_num;
            r_recip <= i_recip;
        end
        if (r_busy) begin
            r_quo <= w_prod[RECIP_SHIFT +: NUM_W];
        end
    end

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/adc_level_tracker_with_counter_compare.sv
`default_nettype none

// Converter samples are summed in groups of GROUP_SIZE; every sample that does not
// close a group is accepted without holding off the input. The sample that closes a
// group also samples the two active-low buttons (a falling edge steps the 8-bit
// counter up or down) and starts the level update, during which no input is
// taken: the group average, the compensated value and the 0..255 target each come
// from one shared unit that divides by a constant through a multiply by its scaled
// reciprocal, so after the closing sample the input is held off through the average,
// cut, compensation, target, step and output states (compensation and target are
// skipped when a cut forces the level), and longer while the previous result still
// waits to be taken. One result per group waits in an output register and is shown
// until it is taken; the next group's samples are accepted meanwhile. Configuration
// writes are taken in any cycle and should only be made while the block is idle.
module adc_level_tracker_with_counter_compare #(
    parameter int GROUP_SIZE = alt_pkg::GROUP_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alt_in_if.sink     i_in,
    alt_out_if.source  o_out,
    alt_cfg_if.sink    i_cfg
);
    import alt_pkg::*;

    localparam int IDX_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(GROUP_SIZE);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GROUP_SIZE - 1);
    localparam logic [RECIP_W-1:0] GROUP_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE));

    t_cfg                w_cfg;
    t_state              r_state, n_state;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [LEVEL_W-1:0]  r_count, n_count;
    logic                r_up_prev, n_up_prev;
    logic                r_dn_prev, n_dn_prev;
    logic [LEVEL_W-1:0]  r_level, n_level;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic [LEVEL_W-1:0]  r_target, n_target;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_avg;
    logic [LEVEL_W-1:0]  r_out_level;
    logic [LEVEL_W-1:0]  r_out_count;
    logic                r_out_above;

    logic                w_accept;
    logic                w_load;
    logic [SUM_W-1:0]    w_total;
    logic                w_up_fall;
    logic                w_dn_fall;
    logic [SAMPLE_W-1:0] w_diff;
    logic [SAMPLE_W-1:0] w_comp;
    logic                w_rise;
    logic [LEVEL_W-1:0]  w_dist;

    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [RECIP_W-1:0]  div_recip;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;

    alt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    alt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_recip (div_recip),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign i_in.ready        = (r_state == ST_IDLE);
    assign w_accept          = i_in.valid && (r_state == ST_IDLE);
    assign w_total           = r_sum + SUM_W'(i_in.sample);
    assign w_up_fall         = r_up_prev && !i_in.up_button;
    assign w_dn_fall         = r_dn_prev && !i_in.down_button;
    assign w_diff            = (r_avg > OFFSET) ? (r_avg - OFFSET) : '0;
    assign w_comp            = (div_quo > NUM_W'(FULL_SCALE)) ? FULL_SCALE
                                                              : div_quo[SAMPLE_W-1:0];
    assign w_rise            = r_target > r_level;
    assign w_dist            = w_rise ? (r_target - r_level) : (r_level - r_target);
    assign w_load            = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);

    assign o_out.valid       = r_out_valid;
    assign o_out.average     = r_out_avg;
    assign o_out.level       = r_out_level;
    assign o_out.count_value = r_out_count;
    assign o_out.level_above = r_out_above;

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_count     = r_count;
        n_up_prev   = r_up_prev;
        n_dn_prev   = r_dn_prev;
        n_level     = r_level;
        n_avg       = r_avg;
        n_target    = r_target;
        n_out_valid = r_out_valid && !o_out.ready;
        div_start   = 1'b0;
        div_num     = '0;
        div_recip   = GROUP_RECIP;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_idx != IDX_LAST) begin
                        n_sum = w_total;
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_sum     = '0;
                        n_idx     = '0;
                        n_up_prev = i_in.up_button;
                        n_dn_prev = i_in.down_button;
                        if (w_up_fall && !w_dn_fall) begin
                            n_count = r_count + 1'b1;
                        end else if (w_dn_fall && !w_up_fall) begin
                            n_count = r_count - 1'b1;
                        end
                        div_start = 1'b1;
                        div_num   = NUM_W'(w_total);
                        div_recip = GROUP_RECIP;
                        n_state   = ST_AVG;
                    end
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    n_avg   = div_quo[SAMPLE_W-1:0];
                    n_state = ST_CUT;
                end
            end
            ST_CUT: begin
                priority if (r_avg < w_cfg.low_cut) begin
                    n_level  = '0;
                    n_target = '0;
                    n_state  = ST_STEP;
                end else if (r_avg > w_cfg.high_cut) begin
                    n_level  = LEVEL_MAX;
                    n_target = LEVEL_MAX;
                    n_state  = ST_STEP;
                end else begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(w_diff) * NUM_W'(FULL_SCALE);
                    div_recip = COMP_RECIP;
                    n_state   = ST_COMP;
                end
            end
            ST_COMP: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(w_comp) * NUM_W'(LEVEL_MAX);
                    div_recip = SCALE_RECIP;
                    n_state   = ST_TGT;
                end
            end
            ST_TGT: begin
                if (div_done) begin
                    n_target = div_quo[LEVEL_W-1:0];
                    n_state  = ST_STEP;
                end
            end
            ST_STEP: begin
                if (w_dist > w_cfg.deadband) begin
                    n_level = w_rise ? (r_level + 1'b1) : (r_level - 1'b1);
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_up_prev   <= 1'b1;
            r_dn_prev   <= 1'b1;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_up_prev   <= n_up_prev;
            r_dn_prev   <= n_dn_prev;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_avg    <= n_avg;
        r_target <= n_target;
        if (w_load) begin
            r_out_avg   <= r_avg;
            r_out_level <= r_level;
            r_out_count <= r_count;
            r_out_above <= r_level > r_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_LAST)
        else $error("sample index beyond group");

    a_low_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CUT && r_avg < w_cfg.low_cut) |=>
            (r_level == '0 && r_state == ST_STEP))
        else $error("low cut did not clear the level");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |=>
            (r_level == $past(r_level) || r_level == $past(r_level) + 8'd1 ||
             r_level == $past(r_level) - 8'd1))
        else $error("level moved more than one step");

    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result presented outside the output state");
`endif

endmodule

`default_nettype wire
